FILE: rtl/core/generational_task_slot_table_macros.svh
// Assertion macros for the generational task slot table.
`ifndef GENERATIONAL_TASK_SLOT_TABLE_MACROS_SVH
`define GENERATIONAL_TASK_SLOT_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define GTST_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gtst assertion failed");
`define GTST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gtst assertion failed");
`else
`define GTST_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define GTST_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/gtst_pkg.sv
// Shared constants and codes of the generational task slot table.
package gtst_pkg;

    localparam int SLOTS_DEF     = 64;
    localparam int GEN_WIDTH_DEF = 32;

    localparam int OP_W          = 3;
    localparam int IDX_FIELD_W   = 6;
    localparam int GEN_FIELD_W   = 32;
    localparam int STATUS_W      = 3;
    localparam int COUNT_FIELD_W = 7;
    localparam int S_TDATA_W     = 40;
    localparam int M_TDATA_W     = 56;

    localparam logic [OP_W-1:0] OP_REGISTER   = 3'd0;
    localparam logic [OP_W-1:0] OP_QUERY      = 3'd1;
    localparam logic [OP_W-1:0] OP_CANCEL     = 3'd2;
    localparam logic [OP_W-1:0] OP_RESUME     = 3'd3;
    localparam logic [OP_W-1:0] OP_FINISH     = 3'd4;
    localparam logic [OP_W-1:0] OP_SUSPEND    = 3'd5;
    localparam logic [OP_W-1:0] OP_CANCEL_ALL = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_STALE    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DEFERRED = 3'd4;

endpackage

FILE: rtl/core/gtst_slot_ram.sv
// Synchronous slot memory with one write port and one registered read port.
module gtst_slot_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 34,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/gtst_free_find.sv
// Priority encoder that finds the lowest slot not in use.
module gtst_free_find #(
    parameter int SLOTS = 64,
    parameter int AW    = 6
) (
    input  logic [SLOTS-1:0] used,
    output logic             found,
    output logic [AW-1:0]    index
);

    always_comb
    begin
        found = 1'b0;
        index = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!used[i])
            begin
                found = 1'b1;
                index = AW'(i);
            end
        end
    end

endmodule

FILE: rtl/core/generational_task_slot_table.sv
// Top level of the generational task slot table: control, slot memory and result register.
// Handle ops and register: a word is accepted in IDLE, its slot is read for EXEC, and the
// result word is registered when EXEC completes (memory read, then write back); no new word is taken until then.
// cancel_all walks the slot memory one entry per cycle, then reports the dropped count.
// Reset is asynchronous and active low; after it the block sweeps every slot memory entry,
// writing generation 1 and clear flags, with s_tready held low.
`include "generational_task_slot_table_macros.svh"

module generational_task_slot_table
    import gtst_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int GEN_WIDTH = GEN_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // From bit 0: slot_index[5:0], generation[31:0], owner_alive, spawn_accepted.
    input  logic [S_TDATA_W-1:0] s_tdata,
    // op[2:0].
    input  logic [OP_W-1:0]      s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // From bit 0: status[2:0], out_index[5:0], out_generation[31:0],
    // dropped_count[6:0], live_count[6:0], one zero pad bit.
    output logic [M_TDATA_W-1:0] m_tdata
);

    // Index and counter widths follow the table depth.
    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    // A memory word holds {awaiting, cancelled, generation}.
    localparam int WORD_W = GEN_WIDTH + 2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_FIN
    } state_t;

    state_t                   state_reg;
    logic [IDX_W-1:0]         walk_reg;
    logic [CNT_W-1:0]         drop_reg;
    logic [CNT_W-1:0]         live_reg;
    logic [SLOTS-1:0]         used_reg;

    // Latched input word.
    logic [OP_W-1:0]          op_reg;
    logic [IDX_W-1:0]         addr_reg;
    logic                     in_range_reg;
    logic [GEN_FIELD_W-1:0]   gen_reg;
    logic                     owner_reg;
    logic                     spawn_reg;
    logic                     full_reg;

    logic                     m_tvalid_reg;
    logic [M_TDATA_W-1:0]     m_tdata_reg;
    logic [M_TDATA_W-1:0]     m_tdata_next;

    // Input field views.
    logic [IDX_FIELD_W-1:0]   in_index;
    logic [GEN_FIELD_W-1:0]   in_gen;
    logic                     in_owner;
    logic                     in_spawn;

    assign in_index = s_tdata[IDX_FIELD_W-1:0];
    assign in_gen   = s_tdata[IDX_FIELD_W +: GEN_FIELD_W];
    assign in_owner = s_tdata[IDX_FIELD_W + GEN_FIELD_W];
    assign in_spawn = s_tdata[IDX_FIELD_W + GEN_FIELD_W + 1];

    logic accept;
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // The result register can be loaded when it is empty or being emptied.
    logic out_free;
    assign out_free = !m_tvalid_reg || m_tready;

    // A result word is loaded when EXEC or FIN completes.
    logic out_load;
    assign out_load = ((state_reg == S_EXEC) || (state_reg == S_FIN)) && out_free;

    // Lowest free slot for register.
    logic             free_found;
    logic [IDX_W-1:0] free_index;

    gtst_free_find #(
        .SLOTS (SLOTS),
        .AW    (IDX_W)
    ) u_free_find (
        .used  (used_reg),
        .found (free_found),
        .index (free_index)
    );

    // Memory read is issued at acceptance, so its data is ready in the EXEC cycle.
    logic [IDX_W-1:0]  rd_addr;
    logic [WORD_W-1:0] rd_word;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [WORD_W-1:0] mem_wdata;

    assign rd_addr = (s_tuser == OP_REGISTER) ? free_index : IDX_W'(in_index);

    gtst_slot_ram #(
        .DEPTH (SLOTS),
        .WIDTH (WORD_W),
        .AW    (IDX_W)
    ) u_slot_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (rd_word)
    );

    // Fields of the slot read for the current word.
    logic [GEN_WIDTH-1:0] st_gen;
    logic                 st_cancelled;
    logic                 st_awaiting;
    logic [GEN_WIDTH-1:0] rel_gen;
    logic                 match;

    assign st_gen       = rd_word[GEN_WIDTH-1:0];
    assign st_cancelled = rd_word[GEN_WIDTH];
    assign st_awaiting  = rd_word[GEN_WIDTH+1];

    // The generation after a release skips 0 when it wraps.
    always_comb
    begin
        rel_gen = st_gen + GEN_WIDTH'(1);
        if (rel_gen == '0)
        begin
            rel_gen = GEN_WIDTH'(1);
        end
    end

    // A handle matches an in-use slot whose stored generation equals the nonzero handle one.
    assign match = in_range_reg && used_reg[addr_reg] && (gen_reg != '0)
                   && (gen_reg == GEN_FIELD_W'(st_gen));

    // Outcome of one handle or register word, applied in the EXEC cycle.
    logic [STATUS_W-1:0]  ex_status;
    logic                 ex_we;
    logic [WORD_W-1:0]    ex_wdata;
    logic                 ex_set_used;
    logic                 ex_clr_used;

    always_comb
    begin
        ex_status   = ST_STALE;
        ex_we       = 1'b0;
        ex_wdata    = {2'b00, rel_gen};
        ex_set_used = 1'b0;
        ex_clr_used = 1'b0;
        if (op_reg == OP_REGISTER)
        begin
            if (full_reg)
            begin
                ex_status = ST_FULL;
            end
            else
            begin
                ex_status   = ST_OK;
                ex_we       = 1'b1;
                ex_wdata    = {2'b00, st_gen};
                ex_set_used = 1'b1;
            end
        end
        else if (match)
        begin
            unique case (op_reg)
                OP_QUERY:
                begin
                    ex_status = ST_OK;
                end
                OP_CANCEL:
                begin
                    ex_we = 1'b1;
                    if (!st_awaiting)
                    begin
                        ex_status   = ST_DROPPED;
                        ex_clr_used = 1'b1;
                    end
                    else
                    begin
                        ex_status = ST_DEFERRED;
                        ex_wdata  = {2'b11, st_gen};
                    end
                end
                OP_RESUME:
                begin
                    ex_we = 1'b1;
                    if (st_cancelled || !owner_reg)
                    begin
                        ex_status   = ST_DROPPED;
                        ex_clr_used = 1'b1;
                    end
                    else
                    begin
                        ex_status = ST_OK;
                        ex_wdata  = {1'b0, st_cancelled, st_gen};
                    end
                end
                OP_FINISH:
                begin
                    ex_status   = ST_OK;
                    ex_we       = 1'b1;
                    ex_clr_used = 1'b1;
                end
                OP_SUSPEND:
                begin
                    ex_we = 1'b1;
                    if (!spawn_reg)
                    begin
                        ex_status   = ST_DROPPED;
                        ex_clr_used = 1'b1;
                    end
                    else
                    begin
                        ex_status = ST_OK;
                        ex_wdata  = {1'b1, st_cancelled, st_gen};
                    end
                end
                default:
                begin
                    // The unused op code reads as a stale handle.
                    ex_status = ST_STALE;
                end
            endcase
        end
    end

    // Memory write: the sweeps write a fresh entry, EXEC writes the modified slot.
    logic exec_fire;
    assign exec_fire = (state_reg == S_EXEC) && out_free;

    always_comb
    begin
        if ((state_reg == S_CLEAR) || (state_reg == S_WALK))
        begin
            mem_we    = 1'b1;
            mem_waddr = walk_reg;
            mem_wdata = {2'b00, GEN_WIDTH'(1)};
        end
        else
        begin
            mem_we    = exec_fire && ex_we;
            mem_waddr = addr_reg;
            mem_wdata = ex_wdata;
        end
    end

    logic             walk_last;
    logic [CNT_W-1:0] live_after;

    assign walk_last = (walk_reg == IDX_W'(SLOTS - 1));

    always_comb
    begin
        live_after = live_reg;
        if (ex_set_used)
        begin
            live_after = live_reg + CNT_W'(1);
        end
        else if (ex_clr_used && (live_reg != '0))
        begin
            live_after = live_reg - CNT_W'(1);
        end
    end

    // Result word: FIN reports the cancel_all count, EXEC the handle or register outcome.
    always_comb
    begin
        m_tdata_next = '0;
        if (state_reg == S_FIN)
        begin
            m_tdata_next[STATUS_W-1:0] = ST_OK;
            m_tdata_next[STATUS_W + IDX_FIELD_W + GEN_FIELD_W +: COUNT_FIELD_W]
                = COUNT_FIELD_W'(drop_reg);
        end
        else
        begin
            m_tdata_next[STATUS_W-1:0] = ex_status;
            if (ex_set_used)
            begin
                m_tdata_next[STATUS_W +: IDX_FIELD_W] = IDX_FIELD_W'(addr_reg);
                m_tdata_next[STATUS_W + IDX_FIELD_W +: GEN_FIELD_W] = GEN_FIELD_W'(st_gen);
            end
            m_tdata_next[STATUS_W + IDX_FIELD_W + GEN_FIELD_W + COUNT_FIELD_W
                         +: COUNT_FIELD_W] = COUNT_FIELD_W'(live_after);
        end
    end

    // Control state machine with the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            walk_reg     <= '0;
            drop_reg     <= '0;
            live_reg     <= '0;
            used_reg     <= '0;
            op_reg       <= OP_REGISTER;
            addr_reg     <= '0;
            in_range_reg <= 1'b0;
            gen_reg      <= '0;
            owner_reg    <= 1'b0;
            spawn_reg    <= 1'b0;
            full_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= m_tdata_next;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    if (walk_last)
                    begin
                        walk_reg  <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        walk_reg <= walk_reg + IDX_W'(1);
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg       <= s_tuser;
                        addr_reg     <= rd_addr;
                        in_range_reg <= (32'(in_index) < 32'(SLOTS));
                        gen_reg      <= in_gen;
                        owner_reg    <= in_owner;
                        spawn_reg    <= in_spawn;
                        full_reg     <= !free_found;
                        if (s_tuser == OP_CANCEL_ALL)
                        begin
                            walk_reg  <= '0;
                            drop_reg  <= '0;
                            state_reg <= S_WALK;
                        end
                        else
                        begin
                            state_reg <= S_EXEC;
                        end
                    end
                end
                S_EXEC:
                begin
                    if (out_free)
                    begin
                        if (ex_set_used)
                        begin
                            used_reg[addr_reg] <= 1'b1;
                        end
                        if (ex_clr_used)
                        begin
                            used_reg[addr_reg] <= 1'b0;
                        end
                        live_reg  <= live_after;
                        state_reg <= S_IDLE;
                    end
                end
                S_WALK:
                begin
                    // Count the slots in use while each entry is rewritten.
                    drop_reg <= drop_reg + CNT_W'(used_reg[walk_reg]);
                    if (walk_last)
                    begin
                        walk_reg  <= '0;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        walk_reg <= walk_reg + IDX_W'(1);
                    end
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        used_reg  <= '0;
                        live_reg  <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The live count always equals the number of slots marked in use.
    `GTST_ASSERT_IMPLIES(a_live_matches_used, clk, rst_n, 1'b1,
        $countones(used_reg) == 32'(live_reg))
    // One word at a time: after an acceptance no further word is taken in the next cycle.
    `GTST_ASSERT_NEXT(a_one_word_in_flight, clk, rst_n, accept, !s_tready)
    // A result that waits holds the EXEC stage, so no result is overwritten.
    `GTST_ASSERT_NEXT(a_exec_holds_on_stall, clk, rst_n,
        (state_reg == S_EXEC) && m_tvalid_reg && !m_tready, state_reg == S_EXEC)
    // Input stays closed during the sweep that follows reset.
    `GTST_ASSERT_IMPLIES(a_no_accept_in_clear, clk, rst_n,
        state_reg == S_CLEAR, !s_tready && !m_tvalid_reg)

endmodule

FILE: bench/generational_task_slot_table_tb.sv
// Self-checking testbench for the generational task slot table.
`timescale 1ns / 1ps

module generational_task_slot_table_tb;
    import gtst_pkg::*;

    // Op code 7 is not assigned to any operation and must read as a stale handle.
    localparam logic [OP_W-1:0] OP_UNKNOWN = 3'd7;

    // Number of random words after the directed table, and where the quiet tail starts.
    localparam int RANDOM_WORDS = 550;
    localparam int QUIET_FROM   = 490;
    localparam int LONG_HOLD    = 200;

    // One result word, unpacked from m_tdata.
    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [IDX_FIELD_W-1:0]   slot;
        logic [GEN_FIELD_W-1:0]   gen;
        logic [COUNT_FIELD_W-1:0] dropped;
        logic [COUNT_FIELD_W-1:0] live;
    } slot_result_t;

    // One row of the directed table. When typed is set, want holds the result
    // that is plain from the table's rules; otherwise the shadow table supplies it.
    typedef struct {
        logic [OP_W-1:0]        op;
        logic [IDX_FIELD_W-1:0] idx;
        logic [GEN_FIELD_W-1:0] gen;
        logic                   owner;
        logic                   spawn;
        bit                     typed;
        slot_result_t           want;
    } table_row_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // From bit 0: slot_index[5:0], generation[31:0], owner_alive, spawn_accepted.
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    // op[2:0].
    logic [OP_W-1:0]      s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // From bit 0: status[2:0], out_index[5:0], out_generation[31:0],
    // dropped_count[6:0], live_count[6:0], one zero pad bit.
    logic [M_TDATA_W-1:0] m_tdata;

    generational_task_slot_table dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // Shadow copy of the slot table, advanced once per accepted input word.
    bit                     tbl_used      [SLOTS_DEF];
    logic [GEN_FIELD_W-1:0] tbl_gen       [SLOTS_DEF];
    bit                     tbl_cancelled [SLOTS_DEF];
    bit                     tbl_awaiting  [SLOTS_DEF];
    int                     tbl_live;

    // Results still owed by the block, oldest first.
    slot_result_t pending_results [$];
    table_row_t   directed_rows   [$];

    int fail_count    = 0;
    bit quiet         = 1'b0;  // set for the tail of the run: no idling on either side
    bit long_hold_req = 1'b0;  // asks the sink to hold m_tready low for a long stretch
    int no_gap_left   = 0;     // words the source sends back to back

    // Releasing a slot bumps its generation; the count wraps past zero to one so that a
    // generation of zero never names a live slot.
    function automatic void retire_slot(input int k);
        tbl_gen[k]       = tbl_gen[k] + 1'b1;
        if (tbl_gen[k] == '0)
            tbl_gen[k] = 1;
        tbl_used[k]      = 1'b0;
        tbl_cancelled[k] = 1'b0;
        tbl_awaiting[k]  = 1'b0;
        if (tbl_live > 0)
            tbl_live--;
    endfunction

    // Applies one input word to the shadow table and returns the result word it causes.
    function automatic slot_result_t slot_table_apply(
        input logic [OP_W-1:0]        op,
        input logic [IDX_FIELD_W-1:0] idx,
        input logic [GEN_FIELD_W-1:0] gen,
        input logic                   owner,
        input logic                   spawn
    );
        slot_result_t r;
        int           i;
        int           k;
        int           dropped;
        bit           found;
        r       = '0;
        r.status = ST_OK;
        k       = 0;
        dropped = 0;
        found   = 1'b0;
        if (op == OP_REGISTER)
        begin
            // Lowest free slot wins.
            for (i = 0; i < SLOTS_DEF && !found; i++)
            begin
                if (!tbl_used[i])
                begin
                    found = 1'b1;
                    k     = i;
                end
            end
            if (!found)
                r.status = ST_FULL;
            else
            begin
                if (tbl_gen[k] == '0)
                    tbl_gen[k] = 1;
                tbl_used[k]      = 1'b1;
                tbl_cancelled[k] = 1'b0;
                tbl_awaiting[k]  = 1'b0;
                tbl_live++;
                r.slot = IDX_FIELD_W'(k);
                r.gen  = tbl_gen[k];
            end
        end
        else if (op == OP_CANCEL_ALL)
        begin
            // Every slot goes, and all generations start over at one.
            for (i = 0; i < SLOTS_DEF; i++)
            begin
                if (tbl_used[i])
                    dropped++;
                tbl_used[i]      = 1'b0;
                tbl_gen[i]       = 1;
                tbl_cancelled[i] = 1'b0;
                tbl_awaiting[i]  = 1'b0;
            end
            tbl_live  = 0;
            r.dropped = COUNT_FIELD_W'(dropped);
        end
        else if (op == OP_UNKNOWN || gen == '0 || !tbl_used[idx] || tbl_gen[idx] != gen)
        begin
            r.status = ST_STALE;
        end
        else
        begin
            k = idx;
            case (op)
                OP_CANCEL:
                begin
                    // A slot that is awaiting keeps running until it resumes.
                    tbl_cancelled[k] = 1'b1;
                    if (!tbl_awaiting[k])
                    begin
                        retire_slot(k);
                        r.status = ST_DROPPED;
                    end
                    else
                        r.status = ST_DEFERRED;
                end
                OP_RESUME:
                begin
                    tbl_awaiting[k] = 1'b0;
                    if (tbl_cancelled[k] || !owner)
                    begin
                        retire_slot(k);
                        r.status = ST_DROPPED;
                    end
                end
                OP_FINISH:
                    retire_slot(k);
                OP_SUSPEND:
                begin
                    tbl_awaiting[k] = 1'b1;
                    if (!spawn)
                    begin
                        retire_slot(k);
                        r.status = ST_DROPPED;
                    end
                end
                default:
                    ;  // a query changes nothing
            endcase
        end
        r.live = COUNT_FIELD_W'(tbl_live);
        return r;
    endfunction

    function automatic table_row_t row(
        input logic [OP_W-1:0]          op,
        input logic [IDX_FIELD_W-1:0]   idx,
        input logic [GEN_FIELD_W-1:0]   gen,
        input logic                     owner,
        input logic                     spawn,
        input bit                       typed,
        input logic [STATUS_W-1:0]      st,
        input logic [IDX_FIELD_W-1:0]   o_slot,
        input logic [GEN_FIELD_W-1:0]   o_gen,
        input logic [COUNT_FIELD_W-1:0] o_dropped,
        input logic [COUNT_FIELD_W-1:0] o_live
    );
        table_row_t t;
        t.op    = op;
        t.idx   = idx;
        t.gen   = gen;
        t.owner = owner;
        t.spawn = spawn;
        t.typed = typed;
        t.want  = '{status: st, slot: o_slot, gen: o_gen, dropped: o_dropped, live: o_live};
        return t;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    // Offers one word, waits for the handshake, then records what the block owes for it.
    // s_tvalid stays high on return so that a back-to-back word needs no second assignment
    // in the same step; a gap, if any, lowers it.
    task automatic send_word(
        input logic [OP_W-1:0]        op,
        input logic [IDX_FIELD_W-1:0] idx,
        input logic [GEN_FIELD_W-1:0] gen,
        input logic                   owner,
        input logic                   spawn,
        input bit                     typed,
        input slot_result_t           want
    );
        slot_result_t predicted;
        s_tuser  <= op;
        s_tdata  <= {spawn, owner, gen, idx};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = slot_table_apply(op, idx, gen, owner, spawn);
        pending_results.push_back(typed ? want : predicted);
        if (no_gap_left > 0)
            no_gap_left--;
        else if (!quiet && $urandom_range(0, 99) < 25)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    // Draws one random word. Most handle ops aim at a live slot with its current
    // generation, so that the deeper flag paths get exercised; the rest carry stale,
    // zero or arbitrary generations.
    task automatic pick_word(
        input  int                     reg_pct,
        output logic [OP_W-1:0]        op,
        output logic [IDX_FIELD_W-1:0] idx,
        output logic [GEN_FIELD_W-1:0] gen,
        output logic                   owner,
        output logic                   spawn
    );
        int r;
        int i;
        int live_slots [$];
        r = $urandom_range(0, 99);
        if (r < reg_pct)
            op = OP_REGISTER;
        else if (r < reg_pct + 1)
            op = OP_CANCEL_ALL;
        else if (r < reg_pct + 3)
            op = OP_UNKNOWN;
        else
            op = OP_W'($urandom_range(OP_QUERY, OP_SUSPEND));
        for (i = 0; i < SLOTS_DEF; i++)
        begin
            if (tbl_used[i])
                live_slots.push_back(i);
        end
        if (live_slots.size() != 0 && $urandom_range(0, 99) < 85)
            idx = IDX_FIELD_W'(live_slots[$urandom_range(0, live_slots.size() - 1)]);
        else
            idx = IDX_FIELD_W'($urandom_range(0, SLOTS_DEF - 1));
        r = $urandom_range(0, 99);
        if (r < 80)
            gen = tbl_gen[idx];
        else if (r < 85)
            gen = '0;
        else if (r < 92)
            gen = tbl_gen[idx] - 1'b1;  // a handle kept past its release
        else if (r < 95)
            gen = '1;
        else
            gen = $urandom();
        owner = ($urandom_range(0, 99) < 75);
        spawn = ($urandom_range(0, 99) < 75);
    endtask

    // Sink: random stretches of back pressure, plus one long hold when the source asks.
    initial
    begin : result_sink
        int hold;
        hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold > 0)
                hold--;
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                m_tready <= 1'b0;
                hold = LONG_HOLD - 1;
            end
            else if (!quiet && $urandom_range(0, 99) < 20)
            begin
                m_tready <= 1'b0;
                hold = $urandom_range(0, 7);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Every accepted result word is matched against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        slot_result_t got;
        slot_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status  = m_tdata[2:0];
            got.slot    = m_tdata[8:3];
            got.gen     = m_tdata[40:9];
            got.dropped = m_tdata[47:41];
            got.live    = m_tdata[54:48];
            if (pending_results.size() == 0)
                note_failure($sformatf("result word with nothing expected: %h", m_tdata));
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.slot !== want.slot
                    || got.gen !== want.gen || got.dropped !== want.dropped
                    || got.live !== want.live)
                    note_failure($sformatf(
                        "expected st=%0d idx=%0d gen=%h drop=%0d live=%0d, got st=%0d idx=%0d gen=%h drop=%0d live=%0d",
                        want.status, want.slot, want.gen, want.dropped, want.live,
                        got.status, got.slot, got.gen, got.dropped, got.live));
            end
        end
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int                     i;
        int                     n;
        int                     reg_pct;
        logic [OP_W-1:0]        op;
        logic [IDX_FIELD_W-1:0] idx;
        logic [GEN_FIELD_W-1:0] gen;
        logic                   owner;
        logic                   spawn;

        for (i = 0; i < SLOTS_DEF; i++)
        begin
            tbl_used[i]      = 1'b0;
            tbl_gen[i]       = 1;
            tbl_cancelled[i] = 1'b0;
            tbl_awaiting[i]  = 1'b0;
        end
        tbl_live = 0;

        // Directed table. Typed rows cover reset state, handle extremes, error codes and
        // cancel_all; the rest walk the flag paths and are checked against the shadow table.
        directed_rows.push_back(row(OP_REGISTER, 0, 0, 0, 0, 1, ST_OK, 0, 1, 0, 1));
        directed_rows.push_back(row(OP_REGISTER, 0, 0, 1, 1, 1, ST_OK, 1, 1, 0, 2));
        directed_rows.push_back(row(OP_QUERY, 0, 1, 0, 0, 1, ST_OK, 0, 0, 0, 2));
        directed_rows.push_back(row(OP_QUERY, 0, 0, 0, 0, 1, ST_STALE, 0, 0, 0, 2));
        directed_rows.push_back(row(OP_QUERY, 0, '1, 1, 1, 1, ST_STALE, 0, 0, 0, 2));
        directed_rows.push_back(row(OP_QUERY, 63, 1, 0, 0, 1, ST_STALE, 0, 0, 0, 2));
        directed_rows.push_back(row(OP_UNKNOWN, 0, 1, 1, 1, 1, ST_STALE, 0, 0, 0, 2));
        directed_rows.push_back(row(OP_CANCEL, 0, 1, 0, 0, 1, ST_DROPPED, 0, 0, 0, 1));
        // The handle released just above must now read as stale.
        directed_rows.push_back(row(OP_QUERY, 0, 1, 0, 0, 1, ST_STALE, 0, 0, 0, 1));
        directed_rows.push_back(row(OP_REGISTER, 0, 0, 0, 0, 0, ST_OK, 0, 0, 0, 0));
        directed_rows.push_back(row(OP_SUSPEND, 0, 2, 0, 1, 0, ST_OK, 0, 0, 0, 0));
        // Cancel while awaiting is deferred until the slot resumes.
        directed_rows.push_back(row(OP_CANCEL, 0, 2, 0, 0, 1, ST_DEFERRED, 0, 0, 0, 2));
        directed_rows.push_back(row(OP_RESUME, 0, 2, 1, 0, 0, ST_OK, 0, 0, 0, 0));
        directed_rows.push_back(row(OP_SUSPEND, 1, 1, 1, 0, 0, ST_OK, 0, 0, 0, 0));
        directed_rows.push_back(row(OP_REGISTER, 0, 0, 0, 0, 0, ST_OK, 0, 0, 0, 0));
        directed_rows.push_back(row(OP_REGISTER, 0, 0, 0, 0, 0, ST_OK, 0, 0, 0, 0));
        directed_rows.push_back(row(OP_RESUME, 1, 2, 0, 1, 0, ST_OK, 0, 0, 0, 0));
        directed_rows.push_back(row(OP_SUSPEND, 0, 3, 0, 1, 0, ST_OK, 0, 0, 0, 0));
        directed_rows.push_back(row(OP_RESUME, 0, 3, 1, 0, 0, ST_OK, 0, 0, 0, 0));
        directed_rows.push_back(row(OP_FINISH, 0, 3, 0, 0, 0, ST_OK, 0, 0, 0, 0));
        directed_rows.push_back(row(OP_REGISTER, 0, 0, 0, 0, 0, ST_OK, 0, 0, 0, 0));
        directed_rows.push_back(row(OP_CANCEL_ALL, 0, 0, 0, 0, 1, ST_OK, 0, 0, 1, 0));
        // Generations start over at one after cancel_all.
        directed_rows.push_back(row(OP_REGISTER, 0, 0, 0, 0, 1, ST_OK, 0, 1, 0, 1));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
            send_word(directed_rows[k].op, directed_rows[k].idx, directed_rows[k].gen,
                      directed_rows[k].owner, directed_rows[k].spawn,
                      directed_rows[k].typed, directed_rows[k].want);

        // Empty the table, then fill it past the top so that register hits the full case.
        send_word(OP_CANCEL_ALL, 0, 0, 0, 0, 0, '0);
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n < SLOTS_DEF + 6)
                reg_pct = 100;
            else
            begin
                case ((n / 60) % 4)
                    0:       reg_pct = 45;
                    1:       reg_pct = 20;
                    2:       reg_pct = 70;
                    default: reg_pct = 30;
                endcase
            end
            if (n == 200)
            begin
                // Sink stalls for a long stretch while the source keeps offering words.
                long_hold_req = 1'b1;
                no_gap_left   = 30;
            end
            if (n == 350)
            begin
                // Source pauses until the block has delivered everything it owes.
                s_tvalid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            if (n == QUIET_FROM)
                quiet = 1'b1;
            pick_word(reg_pct, op, idx, gen, owner, spawn);
            send_word(op, idx, gen, owner, spawn, 0, '0);
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        // Room for any stray word, longer than a full cancel_all walk.
        repeat (SLOTS_DEF + 10) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/gtst_pkg.sv
rtl/core/gtst_slot_ram.sv
rtl/core/gtst_free_find.sv
rtl/core/generational_task_slot_table.sv
bench/generational_task_slot_table_tb.sv
